>>> rtl/core/lzw_pkg.sv
// Shared constants, types and the code packing function of the LZW encoder.
`default_nettype none
package lzw_pkg;
    localparam int HASH_ROWS   = 4096;
    localparam int ROW_W       = $clog2(HASH_ROWS);
    localparam int CAM_ENTRIES = 64;
    localparam int CAM_IDX_W   = (CAM_ENTRIES > 1) ? $clog2(CAM_ENTRIES) : 1;
    localparam int CAM_CNT_W   = $clog2(CAM_ENTRIES + 1);
    localparam int KEY_W       = 20;
    localparam int CODE_W      = 12;
    localparam int SLOT_W      = 1 + CODE_W + KEY_W;
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);

    localparam logic [31:0] HASH_SEED = 32'd524057;
    localparam logic [31:0] HASH_C1   = 32'hcc9e2d51;
    localparam logic [31:0] HASH_C2   = 32'h1b873593;
    localparam logic [31:0] HASH_C3   = 32'he6546b64;
    localparam logic [31:0] HASH_C4   = 32'h85ebca6b;
    localparam logic [31:0] HASH_C5   = 32'hc2b2ae35;
    localparam logic [CODE_W-1:0] FIRST_CODE = 12'd256;

    // One raw input word.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       chunk_end;
    } t_item;

    // One packed output word.
    typedef struct packed {
        logic       dict_full;
        logic       stream_end;
        logic [7:0] packed_byte;
    } t_obyte;

    // Bytes produced by packing one code, and the packer state afterwards.
    typedef struct packed {
        logic [1:0] n;
        logic [7:0] b0;
        logic [7:0] b1;
        logic       phase;
        logic [3:0] held;
    } t_emit;

    // Packs one 12-bit code MSB first; a flush pads the last nibble.
    function automatic t_emit pack_code(input logic phase, input logic [3:0] held,
                                        input logic [CODE_W-1:0] code, input logic flush);
        t_emit e;
        if (!phase) begin
            e.b0 = code[11:4];
            if (flush) begin
                e.n     = 2'd2;
                e.b1    = {code[3:0], 4'h0};
                e.phase = 1'b0;
                e.held  = held;
            end else begin
                e.n     = 2'd1;
                e.b1    = 8'h00;
                e.phase = 1'b1;
                e.held  = code[3:0];
            end
        end else begin
            e.n     = 2'd2;
            e.b0    = {held, code[11:8]};
            e.b1    = code[7:0];
            e.phase = 1'b0;
            e.held  = 4'h0;
        end
        return e;
    endfunction
endpackage
`default_nettype wire

>>> rtl/core/lzw_if.sv
// Valid/ready channel interfaces for input bytes and packed output bytes.
`default_nettype none
interface lzw_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       chunk_end;
    modport source(output valid, output data_byte, output chunk_end, input ready);
    modport sink(input valid, input data_byte, input chunk_end, output ready);
endinterface

interface lzw_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] packed_byte;
    logic       stream_end;
    logic       dict_full;
    modport source(output valid, output packed_byte, output stream_end, output dict_full,
                   input ready);
    modport sink(input valid, input packed_byte, input stream_end, input dict_full,
                 output ready);
endinterface
`default_nettype wire

>>> rtl/core/lzw_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module lzw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                          i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> rtl/core/lzw_hash.sv
// Five-stage murmur-style hash from dictionary key to table row.
`default_nettype none
module lzw_hash (
    input  wire logic                         i_clk,
    input  wire logic [lzw_pkg::KEY_W-1:0]    i_key,
    output logic      [lzw_pkg::ROW_W-1:0]    o_row
);
    logic [31:0] r_s1, r_s2, r_s3, r_s4, r_s5;
    logic [31:0] rot1, h_a, h_b, x3, x4, x5;

    // Key scramble, then the mixing rounds, with a register after every multiply.
    always_comb begin
        rot1 = {r_s1[16:0], r_s1[31:17]};
        h_a  = lzw_pkg::HASH_SEED ^ r_s2;
        h_a  = {h_a[18:0], h_a[31:19]};
        h_b  = (h_a + {h_a[29:0], 2'b00} + lzw_pkg::HASH_C3) ^ r_s2;
        x3   = r_s3 ^ {16'h0, r_s3[31:16]};
        x4   = r_s4 ^ {13'h0, r_s4[31:13]};
        x5   = r_s5 ^ {16'h0, r_s5[31:16]};
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= {{(32 - lzw_pkg::KEY_W){1'b0}}, i_key} * lzw_pkg::HASH_C1;
        r_s2 <= rot1 * lzw_pkg::HASH_C2;
        r_s3 <= h_b;
        r_s4 <= x3 * lzw_pkg::HASH_C4;
        r_s5 <= x4 * lzw_pkg::HASH_C5;
    end

    assign o_row = x5[lzw_pkg::ROW_W-1:0] & lzw_pkg::ROW_W'(lzw_pkg::HASH_ROWS - 1);
endmodule
`default_nettype wire

>>> rtl/core/lzw_front.sv
// Input side: a two-word queue that decouples the byte channel from the dictionary engine.
`default_nettype none
module lzw_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    lzw_in_if.sink              i_byte_in,
    output lzw_pkg::t_item      o_item,
    output logic                o_item_valid,
    input  wire logic           i_pop
);
    lzw_pkg::t_item               r_mem [lzw_pkg::Q_DEPTH];
    logic [lzw_pkg::Q_PTR_W-1:0]  r_wp, r_rp;
    logic [lzw_pkg::Q_PTR_W:0]    r_cnt;
    logic                         push, pop;

    assign i_byte_in.ready = (r_cnt != (lzw_pkg::Q_PTR_W + 1)'(lzw_pkg::Q_DEPTH));
    assign push            = i_byte_in.valid && i_byte_in.ready;
    assign pop             = i_pop && o_item_valid;
    assign o_item_valid    = (r_cnt != '0);
    assign o_item          = r_mem[r_rp];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= '{data_byte: i_byte_in.data_byte, chunk_end: i_byte_in.chunk_end};
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            if (push && !pop) r_cnt <= r_cnt + 1'b1;
            else if (pop && !push) r_cnt <= r_cnt - 1'b1;
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/lzw_back.sv
// Dictionary engine: hash lookup, CAM overflow, insert, code packing and output register.
`default_nettype none
module lzw_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire lzw_pkg::t_item i_item,
    input  wire logic           i_item_valid,
    output logic                o_pop,
    output logic                o_out_valid,
    output lzw_pkg::t_obyte     o_out,
    input  wire logic           i_out_ready
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLASS = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_DEC   = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;
    localparam logic [2:0] S_CLEAR = 3'd6;
    localparam logic [2:0] HASH_CYCLES = 3'd5;

    logic [2:0]                       r_state, r_hcnt;
    logic [lzw_pkg::ROW_W-1:0]        r_clr, r_row, hrow;
    logic                             r_need_clr;
    lzw_pkg::t_item                   r_item;
    logic [lzw_pkg::KEY_W-1:0]        r_key;
    logic [lzw_pkg::CODE_W-1:0]       r_prefix, r_code_ctr;
    logic                             r_chunk_start, r_phase, r_dropping;
    logic [3:0]                       r_held;
    logic [lzw_pkg::CAM_CNT_W-1:0]    r_cam_count;
    logic [lzw_pkg::KEY_W-1:0]        r_cam_key [lzw_pkg::CAM_ENTRIES];
    logic                             r_cam_hit, cam_hit;
    logic [lzw_pkg::CAM_IDX_W-1:0]    r_cam_idx, cam_idx;
    lzw_pkg::t_obyte                  r_obuf [4];
    lzw_pkg::t_obyte                  n_obuf [4];
    logic [2:0]                       r_ocnt, n_ocnt;
    logic [1:0]                       r_oidx;
    logic                             r_ov;
    lzw_pkg::t_obyte                  r_opay;

    logic [lzw_pkg::SLOT_W-1:0]       rd0, rd1, wslot;
    logic [lzw_pkg::CODE_W-1:0]       cam_code, hit_code;
    logic                             we0, we1, we_cam;
    logic                             hit0, hit1, hit, miss, room, full, ins0, ins1, ins_cam;
    logic [lzw_pkg::CODE_W-1:0]       n_prefix, fl_code;
    logic                             n_phase, fl_phase;
    logic [3:0]                       n_held, fl_held;
    lzw_pkg::t_emit                   e1, e2;
    logic                             load;

    // Hash unit and the two table ways.
    lzw_hash u_hash (.i_clk(i_clk), .i_key(r_key), .o_row(hrow));

    assign wslot = (r_state == S_CLEAR) ? '0 : {1'b1, r_code_ctr, r_key};

    lzw_ram #(.WIDTH(lzw_pkg::SLOT_W), .DEPTH(lzw_pkg::HASH_ROWS)) u_way0 (
        .i_clk(i_clk), .i_we(we0), .i_waddr((r_state == S_CLEAR) ? r_clr : r_row),
        .i_wdata(wslot), .i_raddr(hrow), .o_rdata(rd0));

    lzw_ram #(.WIDTH(lzw_pkg::SLOT_W), .DEPTH(lzw_pkg::HASH_ROWS)) u_way1 (
        .i_clk(i_clk), .i_we(we1), .i_waddr((r_state == S_CLEAR) ? r_clr : r_row),
        .i_wdata(wslot), .i_raddr(hrow), .o_rdata(rd1));

    lzw_ram #(.WIDTH(lzw_pkg::CODE_W), .DEPTH(lzw_pkg::CAM_ENTRIES)) u_cam_codes (
        .i_clk(i_clk), .i_we(we_cam),
        .i_waddr(r_cam_count[lzw_pkg::CAM_IDX_W-1:0]), .i_wdata(r_code_ctr),
        .i_raddr(r_cam_idx), .o_rdata(cam_code));

    // CAM search: lowest used entry whose key matches.
    always_comb begin
        cam_hit = 1'b0;
        cam_idx = '0;
        for (int a = lzw_pkg::CAM_ENTRIES - 1; a >= 0; a--) begin
            if (lzw_pkg::CAM_CNT_W'(a) < r_cam_count && r_cam_key[a] == r_key) begin
                cam_hit = 1'b1;
                cam_idx = lzw_pkg::CAM_IDX_W'(a);
            end
        end
    end

    // Lookup result and insert choice once the table rows are read.
    always_comb begin
        hit0     = rd0[lzw_pkg::SLOT_W-1] && rd0[lzw_pkg::KEY_W-1:0] == r_key;
        hit1     = rd1[lzw_pkg::SLOT_W-1] && rd1[lzw_pkg::KEY_W-1:0] == r_key;
        hit      = hit0 || hit1 || r_cam_hit;
        hit_code = hit0 ? rd0[lzw_pkg::SLOT_W-2:lzw_pkg::KEY_W]
                 : hit1 ? rd1[lzw_pkg::SLOT_W-2:lzw_pkg::KEY_W] : cam_code;
        miss     = !hit;
        room     = r_cam_count < lzw_pkg::CAM_CNT_W'(lzw_pkg::CAM_ENTRIES);
        ins0     = miss && !rd0[lzw_pkg::SLOT_W-1];
        ins1     = miss && rd0[lzw_pkg::SLOT_W-1] && !rd1[lzw_pkg::SLOT_W-1];
        ins_cam  = miss && rd0[lzw_pkg::SLOT_W-1] && rd1[lzw_pkg::SLOT_W-1] && room;
        full     = miss && rd0[lzw_pkg::SLOT_W-1] && rd1[lzw_pkg::SLOT_W-1] && !room;
        we0      = (r_state == S_CLEAR) || (r_state == S_DEC && ins0);
        we1      = (r_state == S_CLEAR) || (r_state == S_DEC && ins1);
        we_cam   = (r_state == S_DEC) && ins_cam;
    end

    // Packer: prefix on a miss, flush on a chunk's last byte, or a full marker.
    always_comb begin
        e1       = lzw_pkg::pack_code(r_phase, r_held, r_prefix, 1'b0);
        n_prefix = miss ? {4'h0, r_item.data_byte} : hit_code;
        n_phase  = miss ? e1.phase : r_phase;
        n_held   = miss ? e1.held : r_held;
        fl_code  = r_chunk_start ? {4'h0, r_item.data_byte} : n_prefix;
        fl_phase = r_chunk_start ? 1'b0 : n_phase;
        fl_held  = r_chunk_start ? 4'h0 : n_held;
        e2       = lzw_pkg::pack_code(fl_phase, fl_held, fl_code, 1'b1);
        for (int j = 0; j < 4; j++) n_obuf[j] = r_obuf[j];
        n_ocnt = 3'd0;
        if (!r_chunk_start && full) begin
            n_obuf[0] = '{dict_full: 1'b1, stream_end: 1'b1, packed_byte: 8'h00};
            n_ocnt    = 3'd1;
        end else begin
            if (!r_chunk_start && miss) begin
                n_obuf[0] = '{dict_full: 1'b0, stream_end: 1'b0, packed_byte: e1.b0};
                n_obuf[1] = '{dict_full: 1'b0, stream_end: 1'b0, packed_byte: e1.b1};
                n_ocnt    = {1'b0, e1.n};
            end
            if (r_item.chunk_end) begin
                n_obuf[n_ocnt[1:0]] = '{dict_full: 1'b0, stream_end: 1'b0,
                                        packed_byte: e2.b0};
                n_obuf[2'(n_ocnt + 3'd1)] = '{dict_full: 1'b0, stream_end: 1'b1,
                                              packed_byte: e2.b1};
                n_ocnt = n_ocnt + 3'd2;
            end
        end
    end

    assign o_pop       = (r_state == S_IDLE) && i_item_valid;
    assign load        = (r_state == S_EMIT) && (!r_ov || i_out_ready);
    assign o_out_valid = r_ov;
    assign o_out       = r_opay;

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_hcnt <= (r_state == S_HASH) ? r_hcnt + 3'd1 : 3'd0;
        r_cam_hit <= cam_hit;
        r_cam_idx <= cam_idx;
        if (o_pop) begin
            r_item <= i_item;
            r_key  <= {r_prefix, i_item.data_byte};
        end
        if (r_state == S_RD) r_row <= hrow;
        if (we_cam) r_cam_key[r_cam_count[lzw_pkg::CAM_IDX_W-1:0]] <= r_key;
        if ((r_state == S_DEC) || (r_state == S_CLASS)) begin
            for (int j = 0; j < 4; j++) r_obuf[j] <= n_obuf[j];
            r_ocnt <= n_ocnt;
        end
        if (load) r_opay <= r_obuf[r_oidx];
    end

    // Control sequencer and dictionary state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr         <= '0;
            r_need_clr    <= 1'b1;
            r_prefix      <= '0;
            r_code_ctr    <= lzw_pkg::FIRST_CODE;
            r_chunk_start <= 1'b1;
            r_phase       <= 1'b0;
            r_held        <= 4'h0;
            r_dropping    <= 1'b0;
            r_cam_count   <= '0;
            r_oidx        <= '0;
            r_ov          <= 1'b0;
        end else begin
            if (load) r_ov <= 1'b1;
            else if (i_out_ready) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_item_valid) r_state <= S_CLASS;
                end
                S_CLASS: begin
                    r_oidx <= '0;
                    if (r_dropping) begin
                        if (r_item.chunk_end) begin
                            r_dropping    <= 1'b0;
                            r_chunk_start <= 1'b1;
                        end
                        r_state <= S_IDLE;
                    end else if (r_chunk_start) begin
                        r_code_ctr    <= lzw_pkg::FIRST_CODE;
                        r_prefix      <= {4'h0, r_item.data_byte};
                        r_phase       <= 1'b0;
                        r_held        <= 4'h0;
                        r_cam_count   <= '0;
                        r_chunk_start <= r_item.chunk_end;
                        r_need_clr    <= 1'b1;
                        r_clr         <= '0;
                        r_state       <= r_item.chunk_end ? S_EMIT : S_CLEAR;
                    end else begin
                        r_state <= S_HASH;
                    end
                end
                S_HASH: begin
                    if (r_hcnt == HASH_CYCLES - 3'd1) r_state <= S_RD;
                end
                S_RD: begin
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    r_oidx <= '0;
                    if (full) begin
                        if (r_item.chunk_end) r_chunk_start <= 1'b1;
                        else r_dropping <= 1'b1;
                    end else begin
                        if (miss) r_code_ctr <= r_code_ctr + 1'b1;
                        if (ins_cam) r_cam_count <= r_cam_count + 1'b1;
                        r_prefix <= n_prefix;
                        r_phase  <= r_item.chunk_end ? e2.phase : n_phase;
                        r_held   <= r_item.chunk_end ? e2.held : n_held;
                        if (r_item.chunk_end) r_chunk_start <= 1'b1;
                    end
                    r_state <= (n_ocnt == 3'd0) ? S_IDLE : S_EMIT;
                end
                S_EMIT: begin
                    if (load) begin
                        r_oidx <= r_oidx + 2'd1;
                        if ({1'b0, r_oidx} == r_ocnt - 3'd1) begin
                            r_state <= r_need_clr ? S_CLEAR : S_IDLE;
                        end
                    end
                end
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == lzw_pkg::ROW_W'(lzw_pkg::HASH_ROWS - 1)) begin
                        r_need_clr <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/lzw_encoder_hash_cam_dict.sv
// LZW encoder: byte queue in front, hashed-table and CAM dictionary engine behind it.
// A mid-chunk byte goes through queue pop, classify, hash, table read and decide, in order.
// Up to 4 bytes per input byte leave the output register, one per cycle when unstalled.
// The first byte of a chunk starts a table clearing pass over all HASH_ROWS (4096) rows.
// Reset is synchronous, active low, and also runs that clearing pass before input.
`default_nettype none
module lzw_encoder_hash_cam_dict (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lzw_in_if.sink    i_byte_in,
    lzw_out_if.source o_code_out
);
    lzw_pkg::t_item  item;
    logic            item_valid, pop, out_valid;
    lzw_pkg::t_obyte out_pay;

    // Input queue.
    lzw_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_byte_in(i_byte_in),
        .o_item(item), .o_item_valid(item_valid), .i_pop(pop));

    // Dictionary engine and packer.
    lzw_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(item), .i_item_valid(item_valid),
        .o_pop(pop), .o_out_valid(out_valid), .o_out(out_pay),
        .i_out_ready(o_code_out.ready));

    assign o_code_out.valid       = out_valid;
    assign o_code_out.packed_byte = out_pay.packed_byte;
    assign o_code_out.stream_end  = out_pay.stream_end;
    assign o_code_out.dict_full   = out_pay.dict_full;
endmodule
`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for the hashed-dictionary LZW encoder with a CAM overflow store.
`default_nettype none
module testbench;
    import lzw_pkg::*;

    // One stimulus row of the directed part; typed rows carry their known output words.
    typedef struct {
        logic [7:0] data_byte;
        logic       chunk_end;
        bit         typed;
        int         n_words;
        t_obyte     words[3];
    } t_row;

    logic i_clk;
    logic i_rst_n;
    int   err_count;
    int   burst_left;
    int   sent_items;

    lzw_in_if  byte_ch ();
    lzw_out_if code_ch ();

    lzw_encoder_hash_cam_dict u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte_in  (byte_ch),
        .o_code_out (code_ch)
    );

    // Clock with a period of 4.
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Dictionary mirror: two-way hashed table plus sliced CAM match maps.
    bit [SLOT_W-1:0] slot_mem [HASH_ROWS][2];
    bit [63:0]       cam_hi [4];
    bit [63:0]       cam_mid [512];
    bit [63:0]       cam_lo [512];
    bit [CODE_W-1:0] cam_code [64];
    int              cam_used;
    bit [CODE_W-1:0] free_code;
    bit [CODE_W-1:0] prefix;
    bit              at_chunk_start;
    bit              nib_pending;
    bit [3:0]        nib_held;
    bit              discarding;

    t_obyte step_words[$];
    t_obyte packed_q[$];
    t_obyte typed_words[$];
    bit     use_typed;

    function automatic int unsigned hash_row(logic [KEY_W-1:0] key);
        logic [31:0] k;
        logic [31:0] h;
        k = {12'b0, key} * HASH_C1;
        k = {k[16:0], k[31:17]};
        k = k * HASH_C2;
        h = HASH_SEED ^ k;
        h = {h[18:0], h[31:19]};
        h = h * 32'd5 + HASH_C3;
        h = h ^ k;
        h = h ^ (h >> 16);
        h = h * HASH_C4;
        h = h ^ (h >> 13);
        h = h * HASH_C5;
        h = h ^ (h >> 16);
        return h & (HASH_ROWS - 1);
    endfunction

    function automatic void clear_dictionary();
        for (int r = 0; r < HASH_ROWS; r++) begin
            slot_mem[r][0] = '0;
            slot_mem[r][1] = '0;
        end
        for (int i = 0; i < 4; i++) cam_hi[i] = '0;
        for (int i = 0; i < 512; i++) begin
            cam_mid[i] = '0;
            cam_lo[i]  = '0;
        end
        cam_used = 0;
    endfunction

    function automatic bit find_key(logic [KEY_W-1:0] key, output bit [CODE_W-1:0] code);
        int unsigned r;
        bit [63:0]   m;
        r = hash_row(key);
        code = '0;
        for (int w = 0; w < 2; w++) begin
            if (slot_mem[r][w][SLOT_W-1] && slot_mem[r][w][KEY_W-1:0] == key) begin
                code = slot_mem[r][w][KEY_W +: CODE_W];
                return 1'b1;
            end
        end
        m = cam_hi[key[19:18]] & cam_mid[key[17:9]] & cam_lo[key[8:0]];
        for (int a = 0; a < CAM_ENTRIES; a++) begin
            if (m[a]) begin
                code = cam_code[a];
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Returns 1 when both ways and the CAM are full.
    function automatic bit store_key(logic [KEY_W-1:0] key, bit [CODE_W-1:0] code);
        int unsigned r;
        r = hash_row(key);
        for (int w = 0; w < 2; w++) begin
            if (!slot_mem[r][w][SLOT_W-1]) begin
                slot_mem[r][w] = {1'b1, code, key};
                return 1'b0;
            end
        end
        if (cam_used >= CAM_ENTRIES) return 1'b1;
        cam_hi[key[19:18]][cam_used] = 1'b1;
        cam_mid[key[17:9]][cam_used] = 1'b1;
        cam_lo[key[8:0]][cam_used]   = 1'b1;
        cam_code[cam_used] = code;
        cam_used++;
        return 1'b0;
    endfunction

    function automatic void put_word(bit [7:0] b, bit last, bit full);
        t_obyte w;
        w.packed_byte = b;
        w.stream_end  = last;
        w.dict_full   = full;
        step_words.push_back(w);
    endfunction

    // Packs one code MSB first, two codes to three words.
    function automatic void pack_out(bit [CODE_W-1:0] code, bit flush);
        if (!nib_pending) begin
            put_word(code[11:4], 1'b0, 1'b0);
            if (flush) begin
                put_word({code[3:0], 4'h0}, 1'b1, 1'b0);
            end else begin
                nib_held    = code[3:0];
                nib_pending = 1'b1;
            end
        end else begin
            put_word({nib_held, code[11:8]}, 1'b0, 1'b0);
            put_word(code[7:0], flush, 1'b0);
            nib_held    = 4'h0;
            nib_pending = 1'b0;
        end
    endfunction

    function automatic void encode_byte(bit [7:0] b, bit last);
        bit [KEY_W-1:0]  key;
        bit [CODE_W-1:0] code;
        step_words.delete();
        if (discarding) begin
            if (last) begin
                discarding     = 1'b0;
                at_chunk_start = 1'b1;
            end
            return;
        end
        if (at_chunk_start) begin
            clear_dictionary();
            free_code      = FIRST_CODE;
            prefix         = {4'h0, b};
            nib_pending    = 1'b0;
            nib_held       = 4'h0;
            at_chunk_start = 1'b0;
        end else begin
            key = {prefix, b};
            if (find_key(key, code)) begin
                prefix = code;
            end else begin
                if (store_key(key, free_code)) begin
                    put_word(8'h00, 1'b1, 1'b1);
                    if (last) at_chunk_start = 1'b1;
                    else discarding = 1'b1;
                    return;
                end
                free_code = free_code + 1'b1;
                pack_out(prefix, 1'b0);
                prefix = {4'h0, b};
            end
        end
        if (last) begin
            pack_out(prefix, 1'b1);
            at_chunk_start = 1'b1;
        end
    endfunction

    // Picks the next byte whose key misses and lands in the fullest row.
    function automatic bit [7:0] fill_pick(output bit will_fail);
        bit [CODE_W-1:0] code;
        bit [KEY_W-1:0]  key;
        int              best_score;
        int              score;
        int unsigned     r;
        bit [7:0]        b;
        bit [7:0]        best;
        bit [7:0]        offset;
        best_score = -1;
        offset     = 8'($urandom_range(0, 255));
        best       = offset;
        for (int i = 0; i < 256; i++) begin
            b   = offset + i[7:0];
            key = {prefix, b};
            if (!find_key(key, code)) begin
                r     = hash_row(key);
                score = slot_mem[r][0][SLOT_W-1] + slot_mem[r][1][SLOT_W-1];
                if (score > best_score) begin
                    best_score = score;
                    best       = b;
                end
            end
        end
        will_fail = (best_score == 2) && (cam_used >= CAM_ENTRIES);
        return best;
    endfunction

    // Sends one word in bursts with random gaps; entered and left at a falling edge.
    task automatic send_word(bit [7:0] b, bit last);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                byte_ch.valid = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        byte_ch.valid     = 1'b1;
        byte_ch.data_byte = b;
        byte_ch.chunk_end = last;
        do @(posedge i_clk); while (!byte_ch.ready);
        encode_byte(b, last);
        if (use_typed) begin
            foreach (typed_words[i]) packed_q.push_back(typed_words[i]);
            use_typed = 1'b0;
        end else begin
            foreach (step_words[i]) packed_q.push_back(step_words[i]);
        end
        sent_items++;
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        byte_ch.valid = 1'b0;
        while (packed_q.size() != 0) @(negedge i_clk);
    endtask

    // Builds a chunk that overflows the CAM; optionally ends it on the failing word.
    task automatic overflow_chunk(bit end_on_fail);
        bit       fail;
        bit [7:0] b;
        send_word(8'($urandom_range(0, 255)), 1'b0);
        for (int i = 0; i < 2000; i++) begin
            b = fill_pick(fail);
            if (fail) begin
                send_word(b, end_on_fail);
                if (!end_on_fail) begin
                    repeat ($urandom_range(1, 4)) send_word(8'($urandom_range(0, 255)), 1'b0);
                    send_word(8'($urandom_range(0, 255)), 1'b1);
                end
                return;
            end
            send_word(b, 1'b0);
        end
        send_word(8'h00, 1'b1);
    endtask

    // Receiver stall pattern: a new stall density each time stall_tick wraps to zero.
    int stall_mode;
    int stall_tick;
    always @(negedge i_clk) begin
        if (stall_tick == 0) stall_mode = $urandom_range(0, 3);
        stall_tick = (stall_tick + 1) % 256;
        case (stall_mode)
            0: code_ch.ready = 1'b1;
            1: code_ch.ready = ($urandom_range(0, 9) != 0);
            2: code_ch.ready = ($urandom_range(0, 1) == 1);
            default: code_ch.ready = ($urandom_range(0, 9) == 0);
        endcase
    end

    // Compare each output word with the oldest expectation.
    always @(posedge i_clk) begin
        t_obyte exp_w;
        if (i_rst_n && code_ch.valid && code_ch.ready) begin
            if (packed_q.size() == 0) begin
                $error("unexpected word: packed_byte %h", code_ch.packed_byte);
                err_count++;
            end else begin
                exp_w = packed_q.pop_front();
                if (code_ch.packed_byte !== exp_w.packed_byte) begin
                    $error("packed_byte: expected %h, got %h", exp_w.packed_byte,
                           code_ch.packed_byte);
                    err_count++;
                end
                if (code_ch.stream_end !== exp_w.stream_end) begin
                    $error("stream_end: expected %b, got %b", exp_w.stream_end,
                           code_ch.stream_end);
                    err_count++;
                end
                if (code_ch.dict_full !== exp_w.dict_full) begin
                    $error("dict_full: expected %b, got %b", exp_w.dict_full,
                           code_ch.dict_full);
                    err_count++;
                end
            end
        end
    end

    // Watchdog.
    initial begin
        #(4 * 1500000);
        $display("*** FAILED ***");
        $finish;
    end

    // Main stimulus.
    initial begin
        t_row     rows[$];
        t_row     row;
        int       len;
        int       mode;
        bit [7:0] alpha[4];
        bit [7:0] b;

        i_rst_n           = 1'b0;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = 8'h00;
        byte_ch.chunk_end = 1'b0;
        code_ch.ready     = 1'b0;
        stall_tick        = 0;
        stall_mode        = 0;
        err_count         = 0;
        burst_left        = 0;
        sent_items        = 0;
        use_typed         = 1'b0;
        clear_dictionary();
        for (int i = 0; i < 64; i++) cam_code[i] = '0;
        free_code      = FIRST_CODE;
        prefix         = '0;
        at_chunk_start = 1'b1;
        nib_pending    = 1'b0;
        nib_held       = 4'h0;
        discarding     = 1'b0;

        // Directed rows: single-word chunks at both extremes, then short patterns.
        row = '{8'hFF, 1'b1, 1'b1, 2, '{'{1'b0, 1'b0, 8'h0F}, '{1'b0, 1'b1, 8'hF0}, '0}};
        rows.push_back(row);
        row = '{8'h00, 1'b1, 1'b1, 2, '{'{1'b0, 1'b0, 8'h00}, '{1'b0, 1'b1, 8'h00}, '0}};
        rows.push_back(row);
        row = '{8'h01, 1'b0, 1'b1, 0, '{'0, '0, '0}};
        rows.push_back(row);
        row = '{8'h02, 1'b1, 1'b1, 3, '{'{1'b0, 1'b0, 8'h00}, '{1'b0, 1'b0, 8'h10},
                                         '{1'b0, 1'b1, 8'h02}}};
        rows.push_back(row);
        for (int i = 0; i < 7; i++) begin
            row = '{(i % 2) ? 8'h42 : 8'h41, i == 6, 1'b0, 0, '{'0, '0, '0}};
            rows.push_back(row);
        end
        for (int i = 0; i < 6; i++) begin
            row = '{(i % 2) ? 8'h7F : 8'h80, i == 5, 1'b0, 0, '{'0, '0, '0}};
            rows.push_back(row);
        end
        for (int i = 0; i < 5; i++) begin
            row = '{(i % 2) ? 8'h55 : 8'hAA, i == 4, 1'b0, 0, '{'0, '0, '0}};
            rows.push_back(row);
        end

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[i]) begin
            if (rows[i].typed) begin
                typed_words.delete();
                for (int k = 0; k < rows[i].n_words; k++)
                    typed_words.push_back(rows[i].words[k]);
                use_typed = 1'b1;
            end
            send_word(rows[i].data_byte, rows[i].chunk_end);
        end

        // Hold off until every expected word has come back.
        wait_drained();

        // CAM overflow: once mid-chunk with the tail discarded, once on the last word.
        overflow_chunk(1'b0);
        overflow_chunk(1'b1);

        // Random chunks: mostly short, drawn from a small alphabet or the full byte range.
        while (sent_items < 470) begin
            case ($urandom_range(0, 9))
                0: len = 1;
                1: len = $urandom_range(60, 120);
                default: len = $urandom_range(2, 30);
            endcase
            mode = $urandom_range(0, 2);
            for (int i = 0; i < 4; i++) alpha[i] = 8'($urandom_range(0, 255));
            for (int i = 0; i < len; i++) begin
                if (mode == 0) b = 8'($urandom_range(0, 255));
                else b = alpha[$urandom_range(0, mode == 1 ? 1 : 3)];
                send_word(b, i == len - 1);
            end
            if ($urandom_range(0, 7) == 0) wait_drained();
        end

        wait_drained();
        repeat (64) @(negedge i_clk);
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> filelist.f
rtl/core/lzw_pkg.sv
rtl/core/lzw_if.sv
rtl/core/lzw_ram.sv
rtl/core/lzw_hash.sv
rtl/core/lzw_front.sv
rtl/core/lzw_back.sv
rtl/core/lzw_encoder_hash_cam_dict.sv
verif/testbench.sv
